[sv/gaussian_blur_3x3_defines.svh]
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 assertion macros
// Shared property forms for the concurrent checks of the blur block.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_3X3_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define GB3_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that holds whenever its antecedent holds.
`define GB3_ASSERT_IMPLY(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

`endif

[sv/gb3_pkg.sv]
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 package
// Shared constants, codes and types of the blur block.
// ----------------------------------------------------------------------------
package gb3_pkg;

	localparam int DATA_W         = 16;
	localparam int CFG_W          = 10;
	localparam int CFG_IDX_W      = 1;
	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_PIXEL_BITS = 16;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 10'd512;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 10'd512;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_AW    = 3;
	localparam int OFIFO_CW    = 4;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_PIXEL,
		KIND_DRAIN
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic  emit0;
		logic  blur;
		logic  emit1;
		logic  eof;
	} issue_t;

	typedef struct packed {
		logic [DATA_W-1:0] pixel;
		logic              last;
		logic              eof;
	} result_t;

	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} push_t;

endpackage

[sv/gb3_line_mem.sv]
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 line memory
// Holds the two previous rows, one word per column, registered read port.
// ----------------------------------------------------------------------------
module gb3_line_mem #(
	parameter int DEPTH = gb3_pkg::DEF_MAX_WIDTH,
	parameter int DW    = 2 * gb3_pkg::DEF_PIXEL_BITS
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata
);

	logic [DW-1:0] mem [DEPTH];

	// A read in the cycle of a write to the same entry returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/gb3_ctrl.sv]
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 control
// Configuration registers, frame position counters and request decode.
// ----------------------------------------------------------------------------
`include "gaussian_blur_3x3_defines.svh"

module gb3_ctrl #(
	parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = gb3_pkg::DEF_PIXEL_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gb3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gb3_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gb3_pkg::DATA_W-1:0]       s_tdata,
	input  logic                             s_tuser,
	input  logic                             room,
	output gb3_pkg::issue_t                  issue,
	output logic [$clog2(MAX_WIDTH)-1:0]     issue_addr,
	output logic [PIXEL_BITS-1:0]            issue_pix
);

	import gb3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > CFG_W) ? WW : CFG_W;

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [AW-1:0]    col_q;
	logic [AW-1:0]    drain_q;
	logic [CFG_W-1:0] row_q;

	logic [EW-1:0]    w_raw;
	logic [EW-1:0]    w_eff;
	logic [AW-1:0]    wm1;
	logic [CFG_W-1:0] h_eff;
	logic             row_done;
	logic             accept;

	assign w_raw = EW'(width_q);
	assign w_eff = (w_raw == '0) ? EW'(1) :
		(w_raw > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_raw;
	assign wm1      = AW'(w_eff - EW'(1));
	assign h_eff    = (height_q == '0) ? CFG_W'(1) : height_q;
	assign row_done = (row_q >= h_eff);

	assign s_tready  = room;
	assign accept    = s_tvalid && s_tready;
	assign issue_pix = s_tdata[PIXEL_BITS-1:0];

	always_comb begin
		issue      = '0;
		issue_addr = col_q;
		if (accept) begin
			if (s_tuser == OP_PIXEL && !row_done) begin
				issue.kind  = KIND_PIXEL;
				issue.emit0 = (row_q != '0) && (col_q != '0);
				issue.blur  = (row_q >= CFG_W'(2)) && (col_q >= AW'(2));
				issue.emit1 = (row_q != '0) && (col_q == wm1);
			end else if (s_tuser == OP_DRAIN && row_done) begin
				// The drain counter never reaches the width, so every drain here yields.
				issue.kind = KIND_DRAIN;
				issue.eof  = (drain_q == wm1);
				issue_addr = drain_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else begin
			case (issue.kind)
				KIND_PIXEL: begin
					if (col_q == wm1) begin
						col_q <= '0;
						row_q <= row_q + CFG_W'(1);
					end else begin
						col_q <= col_q + AW'(1);
					end
				end
				KIND_DRAIN: begin
					if (drain_q == wm1) begin
						col_q   <= '0;
						row_q   <= '0;
						drain_q <= '0;
					end else begin
						drain_q <= drain_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	`GB3_ASSERT_ALWAYS(a_col_in_row, col_q <= wm1, "column counter ran past the row")
	`GB3_ASSERT_ALWAYS(a_drain_in_row, drain_q <= wm1, "drain counter ran past the row")
	`GB3_ASSERT_IMPLY(a_drain_after_frame, drain_q != '0, row_done,
		"drain in progress before the frame ended")

endmodule

[sv/gb3_filt.sv]
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 filter datapath
// Line memory read-modify-write, 3x3 window and weighted sum, result staging.
// ----------------------------------------------------------------------------
module gb3_filt #(
	parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = gb3_pkg::DEF_PIXEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gb3_pkg::issue_t               issue,
	input  logic [$clog2(MAX_WIDTH)-1:0]  issue_addr,
	input  logic [PIXEL_BITS-1:0]         issue_pix,
	output gb3_pkg::push_t                push,
	output logic [2:0]                    pend
);

	import gb3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PB = PIXEL_BITS;
	localparam int SW = PB + 4;

	typedef struct packed {
		logic [PB-1:0] top;
		logic [PB-1:0] mid;
		logic [PB-1:0] bot;
	} col_t;

	function automatic logic [PB+1:0] col_sum(input col_t x);
		return (PB+2)'(x.top) + ((PB+2)'(x.mid) << 1) + (PB+2)'(x.bot);
	endfunction

	// Stage 1: memory word arrives, window shifts, results are formed.
	issue_t          issue_s1;
	logic [AW-1:0]   addr_s1;
	logic [PB-1:0]   pix_s1;
	logic            fwd_s1;
	logic [2*PB-1:0] fwd_data_s1;
	col_t            col_a_q;
	col_t            col_b_q;

	logic [2*PB-1:0] mem_rd;
	logic [2*PB-1:0] word;
	logic            mem_we;
	logic [2*PB-1:0] mem_wdata;
	col_t            new_col;
	logic [SW-1:0]   sum;
	logic [PB-1:0]   v0_pix;
	push_t           push_d;
	logic [1:0]      n_s1;
	logic [1:0]      n_s2;

	gb3_line_mem #(
		.DEPTH (MAX_WIDTH),
		.DW    (2 * PB)
	) u_line_mem (
		.clk   (clk),
		.re    (issue.kind != KIND_NONE),
		.raddr (issue_addr),
		.rdata (mem_rd),
		.we    (mem_we),
		.waddr (addr_s1),
		.wdata (mem_wdata)
	);

	// Word layout: upper half is the row two above, lower half the row above.
	assign word      = fwd_s1 ? fwd_data_s1 : mem_rd;
	assign mem_we    = (issue_s1.kind == KIND_PIXEL);
	assign mem_wdata = {word[PB-1:0], pix_s1};

	assign new_col.top = word[2*PB-1:PB];
	assign new_col.mid = word[PB-1:0];
	assign new_col.bot = pix_s1;

	assign sum    = SW'(col_sum(col_a_q)) + (SW'(col_sum(col_b_q)) << 1) + SW'(col_sum(new_col));
	assign v0_pix = issue_s1.blur ? sum[SW-1:4] : col_b_q.mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= '0;
			fwd_s1   <= 1'b0;
		end else begin
			issue_s1 <= issue;
			// The entry the stage-1 pixel writes now is read by this request.
			fwd_s1   <= (issue.kind != KIND_NONE) && mem_we && (issue_addr == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		addr_s1     <= issue_addr;
		pix_s1      <= issue_pix;
		fwd_data_s1 <= mem_wdata;
		if (mem_we) begin
			col_a_q <= col_b_q;
			col_b_q <= new_col;
		end
	end

	always_comb begin
		push_d = '0;
		case (issue_s1.kind)
			KIND_PIXEL: begin
				if (issue_s1.emit0) begin
					push_d.v0       = 1'b1;
					push_d.r0.pixel = DATA_W'(v0_pix);
					push_d.r0.last  = !issue_s1.emit1;
					if (issue_s1.emit1) begin
						push_d.v1       = 1'b1;
						push_d.r1.pixel = DATA_W'(new_col.mid);
						push_d.r1.last  = 1'b1;
					end
				end else if (issue_s1.emit1) begin
					push_d.v0       = 1'b1;
					push_d.r0.pixel = DATA_W'(new_col.mid);
					push_d.r0.last  = 1'b1;
				end
			end
			KIND_DRAIN: begin
				push_d.v0       = 1'b1;
				push_d.r0.pixel = DATA_W'(new_col.mid);
				push_d.r0.last  = 1'b1;
				push_d.r0.eof   = issue_s1.eof;
			end
			default: ;
		endcase
	end

	// Stage 2: up to two results wait here for the output queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= '0;
		end else begin
			push <= push_d;
		end
	end

	assign n_s1 = {1'b0, push_d.v0} + {1'b0, push_d.v1};
	assign n_s2 = {1'b0, push.v0} + {1'b0, push.v1};
	assign pend = {1'b0, n_s1} + {1'b0, n_s2};

endmodule

[sv/gb3_out_fifo.sv]
// ----------------------------------------------------------------------------
// Gaussian blur 3x3 output queue
// Takes up to two results a cycle and hands one a cycle to the receiver while it is ready.
// ----------------------------------------------------------------------------
`include "gaussian_blur_3x3_defines.svh"

module gb3_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gb3_pkg::push_t                push,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gb3_pkg::result_t              out_data,
	output logic [gb3_pkg::OFIFO_CW-1:0]  count
);

	import gb3_pkg::*;

	result_t             buf_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0] wr_q;
	logic [OFIFO_AW-1:0] rd_q;
	logic [OFIFO_CW-1:0] count_q;
	logic [1:0]          push_n;
	logic                pop;

	assign push_n    = {1'b0, push.v0} + {1'b0, push.v1};
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = buf_q[rd_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			buf_q[wr_q] <= push.r0;
		end
		if (push.v1) begin
			buf_q[wr_q + OFIFO_AW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OFIFO_AW'(push_n);
			rd_q    <= rd_q + OFIFO_AW'(pop);
			count_q <= count_q + OFIFO_CW'(push_n) - OFIFO_CW'(pop);
		end
	end

	`GB3_ASSERT_ALWAYS(a_no_overflow,
		(OFIFO_CW+1)'(count_q) + (OFIFO_CW+1)'(push_n) <= (OFIFO_CW+1)'(OFIFO_DEPTH),
		"output queue overflow")
	`GB3_ASSERT_IMPLY(a_eof_is_last, out_valid && out_data.eof, out_data.last,
		"end of frame on a result that is not the last of its request")

endmodule

[sv/gaussian_blur_3x3.sv]
// ----------------------------------------------------------------------------
// Gaussian blur 3x3
// Raster-order 1-2-1 Gaussian filter with two line buffers in one memory.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream: s_tuser is the request kind (pixel or drain),
// s_tdata the grey value. Results leave on the m_ stream one per cycle while
// m_tready is high, one row behind the input; the outer row and column pass
// through unchanged. After a frame, one drain request per column releases the
// last row. The cfg_ port sets image width and height between frames; a write
// also restarts the frame position. The line buffers keep their contents. A
// request is taken every cycle while s_tready is high: each pixel does one read
// and one write of its column's line-memory word, with forwarding when the same
// word is read in the cycle it is written. A request is registered in stage 1,
// its results in stage 2 and the output queue. A pixel request at the end of
// any row but the first yields two results if the width exceeds one, so the
// output queue briefly fills by one. s_tready drops when the 8-entry output
// queue cannot hold the results of every request in flight, so a stalled
// receiver halts the input within the pipeline depth and nothing is lost.
// Reset clears the counters and the queue and sets width and height to 512;
// the line memory needs no clearing, as stale words never reach a result.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3 #(
	parameter int MAX_WIDTH  = gb3_pkg::DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = gb3_pkg::DEF_PIXEL_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gb3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gb3_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gb3_pkg::DATA_W-1:0]    s_tdata,  // [15:0] pixel_in
	input  logic                          s_tuser,  // [0] op
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gb3_pkg::DATA_W-1:0]    m_tdata,  // [15:0] pixel_out
	output logic                          m_tlast,
	output logic                          m_tuser   // [0] end_of_frame
);

	import gb3_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int RW = OFIFO_CW + 1;

	issue_t              issue;
	logic [AW-1:0]       issue_addr;
	logic [PIXEL_BITS-1:0] issue_pix;
	push_t               push;
	logic [2:0]          pend;
	logic [OFIFO_CW-1:0] count;
	logic                room;
	result_t             head;

	// Room for the results already in flight plus two for a new request.
	assign room = (RW'(count) + RW'(pend) + RW'(2)) <= RW'(OFIFO_DEPTH);

	gb3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.room       (room),
		.issue      (issue),
		.issue_addr (issue_addr),
		.issue_pix  (issue_pix)
	);

	gb3_filt #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_filt (
		.clk        (clk),
		.arst_n     (arst_n),
		.issue      (issue),
		.issue_addr (issue_addr),
		.issue_pix  (issue_pix),
		.push       (push),
		.pend       (pend)
	);

	gb3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head),
		.count     (count)
	);

	assign m_tdata = head.pixel;
	assign m_tlast = head.last;
	assign m_tuser = head.eof;

endmodule
